>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define BF3_ASSERT_SAME(lbl, clk, rstn, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (con)) \
		else $error("same-cycle check failed");

// next-cycle implication under an active-low reset
`define BF3_ASSERT_NEXT(lbl, clk, rstn, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (con)) \
		else $error("next-cycle check failed");

`endif

>>> design/bf3_pkg.sv
// shared constants, types and helpers of the bilateral filter
package bf3_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int WEIGHT_FRAC_BITS = 16;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int LW_W = 12;
	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int WGT_W = WEIGHT_FRAC_BITS + 1;
	localparam int PROD_W = 2 * WEIGHT_FRAC_BITS + 1;
	localparam int DEN_W = 2 * WEIGHT_FRAC_BITS + 4;
	localparam int NUM_W = DEN_W + CH_W;
	localparam int CFG_W = WGT_W;
	localparam int CFG_IDX_W = 2;
	localparam int TBL_DEPTH = 1 << CH_W;

	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << WEIGHT_FRAC_BITS;
	localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
	localparam logic [LW_W-1:0] LW_MIN = LW_W'(3);
	localparam logic [LW_W-1:0] LW_MAX = LW_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_EDGE_WEIGHT = 2'd1,
		REG_CORNER_WEIGHT = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] rgb_t;
	typedef rgb_t [8:0] window_t;

	typedef struct packed {
		logic start;
		logic ack;
	} flt_ctrl_t;

	typedef struct packed {
		logic done;
	} flt_stat_t;

	function automatic logic [WGT_W-1:0] sat_weight(input logic [WGT_W-1:0] v);
		return (v > WGT_ONE) ? WGT_ONE : v;
	endfunction

endpackage

>>> design/bf3_ifs.sv
// request and result channel interfaces
interface bf3_req_if;
	import bf3_pkg::*;
	logic valid;
	logic ready;
	logic req_type;
	logic frame_start;
	logic [CH_W-1:0] pix_r;
	logic [CH_W-1:0] pix_g;
	logic [CH_W-1:0] pix_b;
	logic [CH_W-1:0] table_index;
	logic [WGT_W-1:0] table_weight;

	modport source (output valid, req_type, frame_start, pix_r, pix_g, pix_b,
		table_index, table_weight, input ready);
	modport sink (input valid, req_type, frame_start, pix_r, pix_g, pix_b,
		table_index, table_weight, output ready);
endinterface

interface bf3_res_if;
	import bf3_pkg::*;
	logic valid;
	logic ready;
	logic [CH_W-1:0] out_r;
	logic [CH_W-1:0] out_g;
	logic [CH_W-1:0] out_b;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;

	modport source (output valid, out_r, out_g, out_b, out_row, out_col, input ready);
	modport sink (input valid, out_r, out_g, out_b, out_row, out_col, output ready);
endinterface

>>> design/bf3_line_mem.sv
// two-row line store, one word holds the upper and the middle row sample
module bf3_line_mem (
	input  logic                            clk,
	input  logic                            rd_en,
	input  logic [bf3_pkg::COL_W-1:0]       rd_addr,
	output logic [2*bf3_pkg::PIX_W-1:0]     rd_data,
	input  logic                            wr_en,
	input  logic [bf3_pkg::COL_W-1:0]       wr_addr,
	input  logic [2*bf3_pkg::PIX_W-1:0]     wr_data
);
	import bf3_pkg::*;

	logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> design/bf3_filter.sv
// range weight table and sequential weighted-mean unit with restoring divider
module bf3_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tbl_we,
	input  logic [bf3_pkg::CH_W-1:0]    tbl_addr,
	input  logic [bf3_pkg::WGT_W-1:0]   tbl_data,
	input  logic [bf3_pkg::WGT_W-1:0]   edge_w,
	input  logic [bf3_pkg::WGT_W-1:0]   corner_w,
	input  bf3_pkg::window_t            window,
	input  bf3_pkg::flt_ctrl_t          ctrl,
	output bf3_pkg::flt_stat_t          stat,
	output logic [bf3_pkg::CH_W-1:0]    res_r,
	output logic [bf3_pkg::CH_W-1:0]    res_g,
	output logic [bf3_pkg::CH_W-1:0]    res_b
);
	import bf3_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_LOOK, S_MUL, S_ACC, S_DIV, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] chan_q;
	logic [2:0] nb_q;
	logic [2:0] div_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [PROD_W-1:0] w_q;
	logic [CH_W-1:0] v_q;
	logic [WGT_W-1:0] sp_q;
	logic [CH_W-1:0] quo_q;
	logic [CH_W-1:0] res_q [3];

	logic [WGT_W-1:0] tbl_q [TBL_DEPTH];
	logic [WGT_W-1:0] tbl_rd_q;

	logic [3:0] widx;
	logic [CH_W-1:0] cval;
	logic [CH_W-1:0] nval;
	logic [CH_W-1:0] diff;
	logic is_corner;
	logic [NUM_W-1:0] trial;
	logic fits;
	logic [CH_W-1:0] quo_nxt;

	function automatic logic [CH_W-1:0] pick(input rgb_t px, input logic [1:0] ch);
		case (ch)
			2'd0: return px[3*CH_W-1:2*CH_W];
			2'd1: return px[2*CH_W-1:CH_W];
			default: return px[CH_W-1:0];
		endcase
	endfunction

	always_comb begin
		widx = (nb_q < 3'd4) ? {1'b0, nb_q} : ({1'b0, nb_q} + 4'd1);
		cval = pick(window[4], chan_q);
		nval = pick(window[widx], chan_q);
		diff = (nval > cval) ? (nval - cval) : (cval - nval);
		is_corner = (widx == 4'd0) || (widx == 4'd2) || (widx == 4'd6) || (widx == 4'd8);
		trial = NUM_W'(den_q) << div_q;
		fits = (num_q >= trial);
		quo_nxt = quo_q;
		if (fits) begin
			quo_nxt[div_q] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_q[tbl_addr] <= tbl_data;
		end
		if (state_q == S_LOOK) begin
			tbl_rd_q <= tbl_q[diff];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q <= 2'd0;
			nb_q <= 3'd0;
			div_q <= 3'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctrl.start) begin
						chan_q <= 2'd0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					num_q <= NUM_W'(cval) << (2 * WEIGHT_FRAC_BITS);
					den_q <= DEN_W'(1) << (2 * WEIGHT_FRAC_BITS);
					nb_q <= 3'd0;
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					v_q <= nval;
					sp_q <= is_corner ? corner_w : edge_w;
					state_q <= S_MUL;
				end
				S_MUL: begin
					w_q <= PROD_W'(sp_q * tbl_rd_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					den_q <= den_q + DEN_W'(w_q);
					num_q <= num_q + NUM_W'(w_q * v_q);
					if (nb_q == 3'd7) begin
						div_q <= 3'd7;
						quo_q <= '0;
						state_q <= S_DIV;
					end else begin
						nb_q <= nb_q + 3'd1;
						state_q <= S_LOOK;
					end
				end
				S_DIV: begin
					if (fits) begin
						num_q <= num_q - trial;
					end
					quo_q <= quo_nxt;
					if (div_q == 3'd0) begin
						res_q[chan_q] <= quo_nxt;
						if (chan_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							chan_q <= chan_q + 2'd1;
							state_q <= S_INIT;
						end
					end else begin
						div_q <= div_q - 3'd1;
					end
				end
				S_DONE: begin
					if (ctrl.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.done = (state_q == S_DONE);
	assign res_r = res_q[0];
	assign res_g = res_q[1];
	assign res_b = res_q[2];
endmodule

>>> design/bilateral_filter_3x3_rgb.sv
// Bilateral 3x3 RGB filter. A table write leaves the input ready for the next request.
// A pixel is accepted, then the line-store read and write-back follow; a pixel that
// completes a window (row and column at least 2) then holds the input while the
// shared weighting unit runs (per channel a setup step, then per neighbour a table
// read, a weight multiply and an accumulate, then eight restoring-division steps)
// and until the result is moved into the output register.
// The next pixel is taken while that result waits; if it is still waiting when the
// next result is ready, the unit and the input stall until the word is taken.
module bilateral_filter_3x3_rgb (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]       cfg_data,
	bf3_req_if.sink                         req,
	bf3_res_if.source                       res
);
	import bf3_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_LINE, T_FILT} state_t;

	state_t state_q;
	logic [LW_W-1:0] line_width_q;
	logic [WGT_W-1:0] edge_q;
	logic [WGT_W-1:0] corner_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_cur_q;
	logic [ROW_W-1:0] row_cur_q;
	rgb_t px_q;
	window_t win_q;
	logic res_valid_q;
	logic [CH_W-1:0] out_r_q;
	logic [CH_W-1:0] out_g_q;
	logic [CH_W-1:0] out_b_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] pend_row_q;
	logic [COL_W-1:0] pend_col_q;

	logic accept;
	logic pix_acc;
	logic tbl_we;
	logic [COL_W-1:0] rd_col;
	logic [2*PIX_W-1:0] line_rd;
	logic [LW_W-1:0] eff_width;
	logic produce;
	logic load_out;
	flt_ctrl_t fctrl;
	flt_stat_t fstat;
	logic [CH_W-1:0] f_r, f_g, f_b;

	assign req.ready = (state_q == T_IDLE);
	assign accept = req.valid && req.ready;
	assign pix_acc = accept && (req.req_type == REQ_PIXEL);
	assign tbl_we = accept && (req.req_type == REQ_TABLE);
	assign rd_col = req.frame_start ? '0 : col_q;

	assign eff_width = (line_width_q < LW_MIN) ? LW_MIN :
		((line_width_q > LW_MAX) ? LW_MAX : line_width_q);
	assign produce = (row_cur_q >= ROW_W'(2)) && (col_cur_q >= COL_W'(2));
	assign load_out = (state_q == T_FILT) && fstat.done && (!res_valid_q || res.ready);
	assign fctrl.start = (state_q == T_LINE) && produce;
	assign fctrl.ack = load_out;

	bf3_line_mem u_line (
		.clk     (clk),
		.rd_en   (pix_acc),
		.rd_addr (rd_col),
		.rd_data (line_rd),
		.wr_en   (state_q == T_LINE),
		.wr_addr (col_cur_q),
		.wr_data ({line_rd[PIX_W-1:0], px_q})
	);

	bf3_filter u_filt (
		.clk      (clk),
		.arst_n   (arst_n),
		.tbl_we   (tbl_we),
		.tbl_addr (req.table_index),
		.tbl_data (sat_weight(req.table_weight)),
		.edge_w   (edge_q),
		.corner_w (corner_q),
		.window   (win_q),
		.ctrl     (fctrl),
		.stat     (fstat),
		.res_r    (f_r),
		.res_g    (f_g),
		.res_b    (f_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LW_RESET;
			edge_q <= WGT_ONE;
			corner_q <= WGT_ONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				REG_EDGE_WEIGHT: edge_q <= sat_weight(cfg_data);
				REG_CORNER_WEIGHT: corner_q <= sat_weight(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
				out_r_q <= f_r;
				out_g_q <= f_g;
				out_b_q <= f_b;
				out_row_q <= pend_row_q;
				out_col_q <= pend_col_q;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (pix_acc) begin
						col_cur_q <= rd_col;
						row_cur_q <= req.frame_start ? '0 : row_q;
						px_q <= {req.pix_r, req.pix_g, req.pix_b};
						state_q <= T_LINE;
					end
				end
				T_LINE: begin
					for (int r = 0; r < 3; r++) begin
						win_q[3*r] <= win_q[3*r+1];
						win_q[3*r+1] <= win_q[3*r+2];
					end
					win_q[2] <= line_rd[2*PIX_W-1:PIX_W];
					win_q[5] <= line_rd[PIX_W-1:0];
					win_q[8] <= px_q;
					if ((LW_W'(col_cur_q) + LW_W'(1)) >= eff_width) begin
						col_q <= '0;
						row_q <= (row_cur_q < ROW_LAST) ? (row_cur_q + ROW_W'(1)) : row_cur_q;
					end else begin
						col_q <= col_cur_q + COL_W'(1);
						row_q <= row_cur_q;
					end
					pend_row_q <= row_cur_q - ROW_W'(1);
					pend_col_q <= col_cur_q - COL_W'(1);
					state_q <= produce ? T_FILT : T_IDLE;
				end
				T_FILT: begin
					if (load_out) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign res.valid = res_valid_q;
	assign res.out_r = out_r_q;
	assign res.out_g = out_g_q;
	assign res.out_b = out_b_q;
	assign res.out_row = out_row_q;
	assign res.out_col = out_col_q;
endmodule

>>> design/bf3_checker.sv
// port-level checks of the bilateral filter and their binding
`include "assert_macros.svh"

module bf3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_type,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [bf3_pkg::ROW_W-1:0]   res_row,
	input logic [bf3_pkg::COL_W-1:0]   res_col
);
	import bf3_pkg::*;

	`BF3_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`BF3_ASSERT_SAME(a_res_inner, clk, arst_n, res_valid, (res_row != '0) && (res_col != '0))
	`BF3_ASSERT_NEXT(a_pix_busy, clk, arst_n, req_valid && req_ready && (req_type == REQ_PIXEL), !req_ready)
endmodule

bind bilateral_filter_3x3_rgb bf3_checker u_bf3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_row   (res.out_row),
	.res_col   (res.out_col)
);

>>> tb/tb_bilateral_filter_3x3_rgb.sv
// self-checking testbench of the 3x3 bilateral rgb filter with its own pixel predictor
module tb_bilateral_filter_3x3_rgb;
	import bf3_pkg::*;

	localparam int DRAIN_CYCLES = 160;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic req_type;
		logic frame_start;
		rgb_t px;
		logic [CH_W-1:0] idx;
		logic [WGT_W-1:0] wt;
	} req_word_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pix_out_t;

	typedef struct packed {
		req_word_t word;
		logic typed;
		pix_out_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	bf3_req_if req ();
	bf3_res_if res ();

	bilateral_filter_3x3_rgb dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .res(res.source)
	);

	always #1 clk = ~clk;

	// predictor state
	rgb_t line_a [MAX_WIDTH];
	rgb_t line_b [MAX_WIDTH];
	rgb_t win [3][3];
	logic [WGT_W-1:0] range_lut [TBL_DEPTH];
	int unsigned col_cnt, row_cnt;
	logic [LW_W-1:0] width_reg;
	logic [WGT_W-1:0] edge_wgt, corner_wgt;

	pix_out_t pending_pixels [$];
	int errors = 0;
	int pixels_sent = 0, lut_writes = 0, results_seen = 0;
	longint cycles = 0;
	int burst_left = 0;
	rgb_t last_px = '0;
	directed_row_t dir_rows [$];

	function automatic logic [WGT_W-1:0] clip_one(input logic [WGT_W-1:0] v);
		return (v > WGT_ONE) ? WGT_ONE : v;
	endfunction

	function automatic logic [CH_W-1:0] filter_chan(input int unsigned sh);
		int unsigned c, v, d;
		longint unsigned den, num, sp, w;
		c = 32'(win[1][1][sh +: CH_W]);
		den = 64'd1 << (2 * WEIGHT_FRAC_BITS);
		num = den * c;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (!(r == 1 && k == 1)) begin
					v = 32'(win[r][k][sh +: CH_W]);
					d = (v > c) ? v - c : c - v;
					sp = (r != 1 && k != 1) ? 64'(corner_wgt) : 64'(edge_wgt);
					w = sp * range_lut[d[CH_W-1:0]];
					den += w;
					num += w * v;
				end
			end
		end
		num = num / den;
		return (num > 255) ? 8'd255 : num[CH_W-1:0];
	endfunction

	function automatic bit predict_word(input req_word_t wd, output pix_out_t o);
		int unsigned col, eff;
		rgb_t top, mid;
		bit made;
		made = 1'b0;
		o = '0;
		if (wd.req_type == REQ_TABLE) begin
			range_lut[wd.idx] = clip_one(wd.wt);
			return 1'b0;
		end
		if (wd.frame_start) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		col = col_cnt % MAX_WIDTH;
		top = line_b[col];
		mid = line_a[col];
		line_b[col] = mid;
		line_a[col] = wd.px;
		for (int r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = wd.px;
		if (row_cnt >= 2 && col_cnt >= 2) begin
			o.r = filter_chan(16);
			o.g = filter_chan(8);
			o.b = filter_chan(0);
			o.row = ROW_W'(row_cnt - 1);
			o.col = COL_W'(col_cnt - 1);
			made = 1'b1;
		end
		eff = 32'(width_reg);
		if (eff < 3) eff = 3;
		if (eff > MAX_WIDTH) eff = MAX_WIDTH;
		if (col_cnt + 1 >= eff) begin
			col_cnt = 0;
			if (row_cnt < MAX_HEIGHT - 1) row_cnt++;
		end else begin
			col_cnt++;
		end
		return made;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input req_word_t wd, input bit typed, input pix_out_t want);
		pix_out_t o;
		bit made;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.req_type <= wd.req_type;
		req.frame_start <= wd.frame_start;
		req.pix_r <= wd.px[23:16];
		req.pix_g <= wd.px[15:8];
		req.pix_b <= wd.px[7:0];
		req.table_index <= wd.idx;
		req.table_weight <= wd.wt;
		do @(posedge clk); while (!req.ready);
		made = predict_word(wd, o);
		if (typed) pending_pixels.push_back(want);
		else if (made) pending_pixels.push_back(o);
		if (wd.req_type == REQ_TABLE) lut_writes++;
		else pixels_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		wait (pending_pixels.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_LINE_WIDTH: width_reg = val[LW_W-1:0];
			REG_EDGE_WEIGHT: edge_wgt = clip_one(val);
			default: corner_wgt = clip_one(val);
		endcase
	endtask

	function automatic rgb_t next_pixel();
		rgb_t p;
		case ($urandom_range(0, 3))
			0: p = PIX_W'($urandom());
			1: begin
				for (int c = 0; c < 3; c++)
					p[c*8 +: 8] = last_px[c*8 +: 8] + CH_W'($urandom_range(0, 6)) - CH_W'(3);
			end
			2: begin
				for (int c = 0; c < 3; c++)
					p[c*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			end
			default: p = last_px;
		endcase
		last_px = p;
		return p;
	endfunction

	function automatic req_word_t lut_word(input logic [CH_W-1:0] idx);
		req_word_t wd;
		wd = '0;
		wd.req_type = REQ_TABLE;
		wd.idx = idx;
		case ($urandom_range(0, 5))
			0: wd.wt = '0;
			1: wd.wt = WGT_ONE;
			2: wd.wt = WGT_W'($urandom_range(0, 2 ** WGT_W - 1));
			default: wd.wt = WGT_W'($urandom_range(0, WGT_ONE));
		endcase
		return wd;
	endfunction

	task automatic run_phase(input logic [LW_W-1:0] lw, input logic [CFG_W-1:0] ew,
			input logic [CFG_W-1:0] cw, input int npix, input bit restart, input bit noisy);
		req_word_t wd;
		int n;
		settle();
		write_reg(REG_LINE_WIDTH, CFG_W'(lw));
		write_reg(REG_EDGE_WEIGHT, ew);
		write_reg(REG_CORNER_WEIGHT, cw);
		n = 0;
		while (n < npix) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				send_word(lut_word(CH_W'($urandom())), 1'b0, '0);
			end else begin
				wd = '0;
				wd.req_type = REQ_PIXEL;
				wd.frame_start = (restart && n == 0) || (noisy && $urandom_range(0, 199) == 0);
				wd.px = next_pixel();
				wd.idx = CH_W'($urandom());
				wd.wt = WGT_W'($urandom());
				send_word(wd, 1'b0, '0);
				n++;
			end
		end
	endtask

	// receiver with changing stall patterns and one long hold-off
	initial begin
		int mode, left, hold;
		bit held;
		mode = 0;
		left = 0;
		hold = 0;
		held = 1'b0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 30) begin
				held = 1'b1;
				hold = 700;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 300);
			end
			left--;
			if (hold > 0) begin
				hold--;
				res.ready <= 1'b0;
			end else begin
				case (mode)
					0: res.ready <= 1'b1;
					1: res.ready <= 1'($urandom_range(0, 1));
					2: res.ready <= ($urandom_range(0, 3) != 0);
					default: res.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		pix_out_t w;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				$display("unexpected result word at row %0d col %0d", res.out_row, res.out_col);
				errors++;
			end else begin
				w = pending_pixels.pop_front();
				if (res.out_r !== w.r) report_mismatch("out_r", int'(res.out_r), int'(w.r));
				if (res.out_g !== w.g) report_mismatch("out_g", int'(res.out_g), int'(w.g));
				if (res.out_b !== w.b) report_mismatch("out_b", int'(res.out_b), int'(w.b));
				if (res.out_row !== w.row)
					report_mismatch("out_row", int'(res.out_row), int'(w.row));
				if (res.out_col !== w.col)
					report_mismatch("out_col", int'(res.out_col), int'(w.col));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d words outstanding", pending_pixels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic directed_row_t drow(input logic rt, input logic fs, input rgb_t px,
			input logic [CH_W-1:0] idx, input logic [WGT_W-1:0] wt, input logic typed,
			input pix_out_t want);
		directed_row_t d;
		d.word.req_type = rt;
		d.word.frame_start = fs;
		d.word.px = px;
		d.word.idx = idx;
		d.word.wt = wt;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	initial begin
		req_word_t wd;
		req.valid = 1'b0;
		req.req_type = REQ_PIXEL;
		req.frame_start = 1'b0;
		req.pix_r = '0;
		req.pix_g = '0;
		req.pix_b = '0;
		req.table_index = '0;
		req.table_weight = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_a[i] = '0;
			line_b[i] = '0;
		end
		for (int i = 0; i < TBL_DEPTH; i++) range_lut[i] = '0;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++) win[r][k] = '0;
		col_cnt = 0;
		row_cnt = 0;
		width_reg = LW_RESET;
		edge_wgt = WGT_ONE;
		corner_wgt = WGT_ONE;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: flat frame gives its own color back, then a 0/255 checkerboard
		dir_rows.push_back(drow(REQ_TABLE, 1'b0, '0, 8'd0, WGT_ONE, 1'b0, '0));
		dir_rows.push_back(drow(REQ_TABLE, 1'b0, '0, 8'd255, '0, 1'b0, '0));
		dir_rows.push_back(drow(REQ_TABLE, 1'b0, '0, 8'd1, 17'h1ffff, 1'b0, '0));
		for (int i = 0; i < 9; i++)
			dir_rows.push_back(drow(REQ_PIXEL, i == 0, 24'hff0080, '0, '0, i == 8,
				{8'hff, 8'h00, 8'h80, 12'd1, 11'd1}));
		for (int i = 0; i < 9; i++)
			dir_rows.push_back(drow(REQ_PIXEL, i == 0, (i % 2) ? 24'h00ff00 : 24'hff00ff,
				'0, '0, 1'b0, '0));
		write_reg(REG_LINE_WIDTH, CFG_W'(3));
		foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

		settle();
		for (int i = 0; i < TBL_DEPTH; i++) send_word(lut_word(CH_W'(i)), 1'b0, '0);

		run_phase(12'd3, WGT_ONE, WGT_ONE, 120, 1'b1, 1'b1);
		run_phase(12'd4, 17'd0, 17'd0, 110, 1'b1, 1'b1);
		run_phase(12'd5, 17'h1ffff, 17'd32768, 140, 1'b1, 1'b1);
		run_phase(12'd0, CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 65536)),
			110, 1'b1, 1'b1);
		run_phase(12'd2, CFG_W'($urandom()), CFG_W'($urandom()), 110, 1'b1, 1'b1);
		run_phase(12'd4095, CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom()),
			200, 1'b1, 1'b1);
		run_phase(12'd2048, WGT_ONE, 17'd0, 150, 1'b1, 1'b1);
		run_phase(12'd8, CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 65536)),
			140, 1'b1, 1'b1);
		// width shrinks in the middle of a row
		run_phase(12'd8, CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 65536)),
			20, 1'b1, 1'b0);
		run_phase(12'd5, CFG_W'($urandom_range(0, 65536)), CFG_W'($urandom_range(0, 65536)),
			30, 1'b0, 1'b1);
		run_phase(12'd16, CFG_W'($urandom()), CFG_W'($urandom_range(0, 65536)),
			180, 1'b1, 1'b1);

		settle();
		$display("covered %0d pixels and %0d range table writes over 11 register settings",
			pixels_sent, lut_writes);
		$display("checked %0d filtered pixels, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/bf3_pkg.sv
design/bf3_ifs.sv
design/bf3_line_mem.sv
design/bf3_filter.sv
design/bilateral_filter_3x3_rgb.sv
design/bf3_checker.sv
tb/tb_bilateral_filter_3x3_rgb.sv
